### rtl/text_console_writer_assert.svh
// assertion macros used by the text console sequencer
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TCW_ASSERT_IMP(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("text console same-cycle check failed");

// next-cycle implication, disabled during reset
`define TCW_ASSERT_NXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("text console next-cycle check failed");

`endif

### rtl/tcw_pkg.sv
// shared constants, types and state codes of the text console
package tcw_pkg;

	localparam int COLUMNS        = 80;
	localparam int ROWS           = 25;
	localparam int CELL_COUNT     = ROWS * COLUMNS;
	localparam int LAST_ROW_START = (ROWS - 1) * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int PTR_W  = $clog2(CELL_COUNT + 1);
	localparam int CUR_W  = $clog2(CELL_COUNT + COLUMNS);
	localparam int COL_W  = $clog2(COLUMNS);

	localparam int CELL_W  = 16;
	localparam int CHAR_W  = 8;
	localparam int ATTR_W  = 8;
	localparam int IDX_W   = 11;
	localparam int POS_W   = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int TAB_STEP = 4;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'h0c;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	localparam logic [ATTR_W-1:0] CLEAR_ATTR = 8'h0f;
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

	// register index, taken from paddr above the byte offset
	localparam logic REG_TEXT_ATTR = 1'b0;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_SCROLL,
		ST_ZROW,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic              fire;
		logic [POS_W-1:0]  cursor_pos;
		logic [CELL_W-1:0] cell_data;
	} emit_t;

endpackage

### rtl/tcw_store.sv
// screen cell memory: one write port, one registered read port
module tcw_store (
	input  logic                               clk,
	input  tcw_pkg::mem_req_t                  mem_req,
	output logic [tcw_pkg::CELL_W-1:0]         rd_data
);

	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (mem_req.re) begin
			rd_data <= mem[mem_req.raddr];
		end
	end

endmodule

### rtl/tcw_seq.sv
// sequencer: cursor tracking, character handling and memory sweeps
`include "text_console_writer_assert.svh"

module tcw_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]         char_code,
	input  logic                               lone_char,
	input  logic [tcw_pkg::IDX_W-1:0]          cell_index,
	input  logic [tcw_pkg::ATTR_W-1:0]         text_attr,
	input  logic [tcw_pkg::CELL_W-1:0]         rd_data,
	output tcw_pkg::mem_req_t                  mem_req,
	output tcw_pkg::emit_t                     emit,
	input  logic                               out_free
);

	tcw_pkg::state_t state_q, state_d;

	logic [tcw_pkg::CUR_W-1:0]  cursor_q;
	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic [tcw_pkg::PTR_W-1:0]  ptr_q;
	logic                       rd_ok_q;
	logic                       wr_pend_s1;
	logic [tcw_pkg::ADDR_W-1:0] wr_addr_s1;

	logic                       accept;
	logic                       is_read;
	logic                       is_clear;
	logic                       idx_ok;
	logic                       ptr_last;
	logic                       ptr_end;
	logic [tcw_pkg::CUR_W-1:0]  cur_nxt;
	logic [tcw_pkg::COL_W-1:0]  col_nxt;
	logic [tcw_pkg::COL_W:0]    col_sum;
	logic                       wrap;
	logic                       char_we;
	logic [tcw_pkg::ADDR_W-1:0] char_addr;
	logic [tcw_pkg::CELL_W-1:0] char_data;

	assign accept   = in_valid && (state_q == tcw_pkg::ST_IDLE);
	assign is_read  = (cmd == tcw_pkg::CMD_READ);
	assign is_clear = lone_char && (char_code == tcw_pkg::CH_FORMFEED);
	assign idx_ok   = 32'(cell_index) < 32'(tcw_pkg::CELL_COUNT);
	assign ptr_last = (ptr_q == tcw_pkg::PTR_W'(tcw_pkg::CELL_COUNT - 1));
	assign ptr_end  = (ptr_q == tcw_pkg::PTR_W'(tcw_pkg::CELL_COUNT));
	assign col_sum  = {1'b0, col_q} + (tcw_pkg::COL_W + 1)'(tcw_pkg::TAB_STEP);
	assign wrap     = (cur_nxt >= tcw_pkg::CUR_W'(tcw_pkg::CELL_COUNT));

	// cursor and column after one character
	always_comb begin
		cur_nxt   = cursor_q + 1'b1;
		col_nxt   = (col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) ? '0 : col_q + 1'b1;
		char_we   = 1'b1;
		char_addr = cursor_q[tcw_pkg::ADDR_W-1:0];
		char_data = {text_attr, char_code};
		case (char_code)
			tcw_pkg::CH_NEWLINE: begin
				cur_nxt = cursor_q - tcw_pkg::CUR_W'(col_q) + tcw_pkg::CUR_W'(tcw_pkg::COLUMNS);
				col_nxt = '0;
				char_we = 1'b0;
			end
			tcw_pkg::CH_TAB: begin
				cur_nxt = cursor_q + tcw_pkg::CUR_W'(tcw_pkg::TAB_STEP);
				if (col_sum >= (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS)) begin
					col_nxt = tcw_pkg::COL_W'(col_sum - (tcw_pkg::COL_W + 1)'(tcw_pkg::COLUMNS));
				end else begin
					col_nxt = tcw_pkg::COL_W'(col_sum);
				end
				char_we = 1'b0;
			end
			tcw_pkg::CH_BACKSPACE: begin
				// clamps at home, blanks the cell under the new cursor
				if (cursor_q != '0) begin
					cur_nxt = cursor_q - 1'b1;
					col_nxt = (col_q == '0) ? tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : col_q - 1'b1;
				end else begin
					cur_nxt = cursor_q;
					col_nxt = col_q;
				end
				char_addr = cur_nxt[tcw_pkg::ADDR_W-1:0];
				char_data = {text_attr, tcw_pkg::CH_SPACE};
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				if (ptr_last) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (accept) begin
					if (is_read) state_d = tcw_pkg::ST_READ;
					else if (is_clear) state_d = tcw_pkg::ST_CLEAR;
					else if (wrap) state_d = tcw_pkg::ST_SCROLL;
					else state_d = tcw_pkg::ST_EMIT;
				end
			end
			tcw_pkg::ST_READ, tcw_pkg::ST_EMIT: begin
				if (out_free) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_SCROLL: begin
				if (ptr_end) state_d = tcw_pkg::ST_ZROW;
			end
			tcw_pkg::ST_ZROW, tcw_pkg::ST_CLEAR: begin
				if (ptr_last) state_d = tcw_pkg::ST_EMIT;
			end
			default: state_d = tcw_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_req         = '0;
		emit.fire       = 1'b0;
		emit.cursor_pos = tcw_pkg::POS_W'(cursor_q);
		emit.cell_data  = '0;
		in_stall        = 1'b1;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q[tcw_pkg::ADDR_W-1:0];
			end
			tcw_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (accept && is_read) begin
					mem_req.re    = idx_ok;
					mem_req.raddr = tcw_pkg::ADDR_W'(cell_index);
				end else if (accept && !is_clear) begin
					mem_req.we    = char_we;
					mem_req.waddr = char_addr;
					mem_req.wdata = char_data;
				end
			end
			tcw_pkg::ST_READ: begin
				emit.fire      = out_free;
				emit.cell_data = rd_ok_q ? rd_data : '0;
			end
			tcw_pkg::ST_EMIT: begin
				emit.fire = out_free;
			end
			tcw_pkg::ST_SCROLL: begin
				// read one row ahead, write back the cell read last cycle
				mem_req.re    = !ptr_end;
				mem_req.raddr = ptr_q[tcw_pkg::ADDR_W-1:0];
				mem_req.we    = wr_pend_s1;
				mem_req.waddr = wr_addr_s1;
				mem_req.wdata = rd_data;
			end
			tcw_pkg::ST_ZROW: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q[tcw_pkg::ADDR_W-1:0];
			end
			tcw_pkg::ST_CLEAR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ptr_q[tcw_pkg::ADDR_W-1:0];
				mem_req.wdata = {tcw_pkg::CLEAR_ATTR, tcw_pkg::CH_SPACE};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tcw_pkg::ST_INIT;
			cursor_q   <= '0;
			col_q      <= '0;
			ptr_q      <= '0;
			rd_ok_q    <= 1'b0;
			wr_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			wr_pend_s1 <= (state_q == tcw_pkg::ST_SCROLL) && !ptr_end;
			case (state_q)
				tcw_pkg::ST_IDLE: begin
					if (accept) begin
						rd_ok_q <= idx_ok;
						if (is_read) begin
						end else if (is_clear) begin
							cursor_q <= '0;
							col_q    <= '0;
							ptr_q    <= '0;
						end else if (wrap) begin
							cursor_q <= tcw_pkg::CUR_W'(tcw_pkg::LAST_ROW_START);
							col_q    <= '0;
							ptr_q    <= tcw_pkg::PTR_W'(tcw_pkg::COLUMNS);
						end else begin
							cursor_q <= cur_nxt;
							col_q    <= col_nxt;
						end
					end
				end
				tcw_pkg::ST_SCROLL: begin
					if (ptr_end) ptr_q <= tcw_pkg::PTR_W'(tcw_pkg::LAST_ROW_START);
					else ptr_q <= ptr_q + 1'b1;
				end
				tcw_pkg::ST_INIT, tcw_pkg::ST_ZROW, tcw_pkg::ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// destination of each scrolled cell, one row above its source
	always_ff @(posedge clk) begin
		wr_addr_s1 <= tcw_pkg::ADDR_W'(ptr_q - tcw_pkg::PTR_W'(tcw_pkg::COLUMNS));
	end

	`TCW_ASSERT_IMP(a_cursor_range, clk, arst_n, 1'b1, cursor_q < tcw_pkg::CUR_W'(tcw_pkg::CELL_COUNT))
	`TCW_ASSERT_IMP(a_col_range, clk, arst_n, 1'b1, col_q < tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) || col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1))
	`TCW_ASSERT_IMP(a_no_rw_overlap, clk, arst_n, mem_req.re && mem_req.we, mem_req.raddr != mem_req.waddr)
	`TCW_ASSERT_NXT(a_clear_homes, clk, arst_n, state_q == tcw_pkg::ST_CLEAR && state_d == tcw_pkg::ST_EMIT, cursor_q == '0 && col_q == '0)

endmodule

### rtl/text_console_writer.sv
// top level of the text console: register port, sequencer, cell memory, result register
//
// text console of ROWS x COLUMNS 16-bit cells (attribute high byte, character low byte)
// input channel: in_valid/in_stall with cmd, char_code, lone_char, cell_index; a transfer
//   happens when in_valid is high and in_stall is low
// cmd write: newline, tab, backspace and ordinary characters move the cursor; a lone
//   form feed clears every cell to space on attribute 0x0f and homes the cursor
// cmd read: returns the cell at cell_index, zero when the index is off screen
// output channel: out_valid/out_stall with cursor_pos and cell_data, one transfer per item
// reads and ordinary characters: the result register loads in the read or emit state that
//   follows the input transfer, once it is free; no new item is taken until back in idle
// scroll: each row is copied up one row through the cell memory, then the last row is zeroed;
//   form feed clear: one pass writes space on attribute 0x0f to every cell
// reset: cursor and text_attribute go home, then a clearing pass over all ROWS*COLUMNS cells
//   zeroes the memory while in_stall stays high; register writes are taken
// a stalled result stays in the output register; one more item is taken meanwhile and
//   holds in_stall high until the result register frees up
// text_attribute lives at byte address 0 of the apb port; pready is always high
module text_console_writer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [tcw_pkg::CHAR_W-1:0]         char_code,
	input  logic                               lone_char,
	input  logic [tcw_pkg::IDX_W-1:0]          cell_index,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tcw_pkg::POS_W-1:0]          cursor_pos,
	output logic [tcw_pkg::CELL_W-1:0]         cell_data,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tcw_pkg::PADDR_W-1:0]        paddr,
	input  logic [tcw_pkg::PDATA_W-1:0]        pwdata,
	output logic [tcw_pkg::PDATA_W-1:0]        prdata,
	output logic                               pready
);

	logic [tcw_pkg::ATTR_W-1:0] attr_q;
	logic                       reg_hit;
	logic                       out_valid_q;
	logic [tcw_pkg::POS_W-1:0]  cursor_pos_q;
	logic [tcw_pkg::CELL_W-1:0] cell_data_q;
	logic                       out_free;
	logic [tcw_pkg::CELL_W-1:0] rd_data;
	tcw_pkg::mem_req_t          mem_req;
	tcw_pkg::emit_t             emit;

	// register port: word decode, byte offset ignored
	assign pready  = 1'b1;
	assign reg_hit = (paddr[tcw_pkg::PADDR_W-1:2] == tcw_pkg::REG_TEXT_ATTR);
	assign prdata  = reg_hit ? tcw_pkg::PDATA_W'(attr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			attr_q <= pwdata[tcw_pkg::ATTR_W-1:0];
		end
	end

	// result register frees when empty or when its transfer completes
	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_data  = cell_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.fire) begin
			cursor_pos_q <= emit.cursor_pos;
			cell_data_q  <= emit.cell_data;
		end
	end

	tcw_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.char_code  (char_code),
		.lone_char  (lone_char),
		.cell_index (cell_index),
		.text_attr  (attr_q),
		.rd_data    (rd_data),
		.mem_req    (mem_req),
		.emit       (emit),
		.out_free   (out_free)
	);

	tcw_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

endmodule
